// ===== design/nisr_pkg.sv =====
// Shared constants, types and state codes for the Newton integer square root core.
`default_nettype none
package nisr_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int LIMIT_WIDTH     = 8;
   localparam int DIV_COUNT_WIDTH = $clog2(DATA_WIDTH);

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(32);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DATA_WIDTH-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== design/nisr_divider.sv =====
// Radix-2 restoring divider that produces one quotient bit per cycle.
`default_nettype none
module nisr_divider
   import nisr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [DATA_WIDTH-1:0]      rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]      quo_ff, quo_in;
   logic [DATA_WIDTH-1:0]      divisor_ff, divisor_in;
   logic [DATA_WIDTH:0]        shifted;
   logic [DATA_WIDTH:0]        trial;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      shifted    = {rem_ff, quo_ff[DATA_WIDTH-1]};
      trial      = shifted - {1'b0, divisor_ff};
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_COUNT_WIDTH'(DATA_WIDTH - 1);
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[DATA_WIDTH]) begin
            rem_in = trial[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

// ===== design/newton_integer_square_root_core.sv =====
// Top level of the Newton integer square root core: iteration sequencer and result register.
// A negative operand returns its word in the cycle after acceptance.
// Otherwise the core runs Newton steps up to the iteration limit, stopping once the estimate
// no longer decreases; each new estimate waits on the bit-serial divider for n / x.
// One operand is in flight at a time; for a non-negative operand busy is high until its result word is strobed.
// Synchronous active-high reset restores the iteration limit to 32 and idles the core.
// The receiver cannot stall; each result word is valid for exactly one cycle.
`default_nettype none
module newton_integer_square_root_core
   import nisr_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [DATA_WIDTH-1:0] req_operand,
   output logic                              rsp_valid,
   output logic signed [DATA_WIDTH-1:0]      rsp_root,
   output logic [LIMIT_WIDTH-1:0]            rsp_iterations_used,
   input  wire logic                         csr_write_enable,
   input  wire logic [LIMIT_WIDTH-1:0]       csr_write_data
);

   state_type              state_ff, state_in;
   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic [DATA_WIDTH-1:0]  n_ff, n_in;
   logic [DATA_WIDTH-1:0]  x_ff, x_in;
   logic [DATA_WIDTH-1:0]  next_ff, next_in;
   logic [LIMIT_WIDTH-1:0] steps_ff, steps_in;
   logic                   valid_ff, valid_in;
   logic [DATA_WIDTH-1:0]  root_ff, root_in;
   logic [LIMIT_WIDTH-1:0] iter_ff, iter_in;
   logic [DATA_WIDTH:0]    sum;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   nisr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign limit_in = csr_write_enable ? csr_write_data : limit_ff;

   always_comb begin
      state_in         = state_ff;
      n_in             = n_ff;
      x_in             = x_ff;
      next_in          = next_ff;
      steps_in         = steps_ff;
      valid_in         = 1'b0;
      root_in          = root_ff;
      iter_in          = iter_ff;
      div_req.start    = 1'b0;
      div_req.dividend = n_ff;
      div_req.divisor  = next_ff;
      sum              = {1'b0, x_ff} + {1'b0, div_rsp.quotient};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_operand[DATA_WIDTH-1]) begin
                  valid_in = 1'b1;
                  root_in  = '1;
                  iter_in  = '0;
               end else begin
                  n_in     = req_operand;
                  x_in     = req_operand;
                  next_in  = DATA_WIDTH'(({1'b0, req_operand} + 1'b1) >> 1);
                  steps_in = '0;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if ((steps_ff < limit_ff) && (next_ff < x_ff)) begin
               x_in     = next_ff;
               if (next_ff == '0) begin
                  steps_in = steps_ff + 1'b1;
                  valid_in = 1'b1;
                  root_in  = next_ff;
                  iter_in  = steps_ff + 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end else begin
               valid_in = 1'b1;
               root_in  = x_ff;
               iter_in  = steps_ff;
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               next_in  = sum[DATA_WIDTH:1];
               steps_in = steps_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         limit_ff <= LIMIT_RESET;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         valid_ff <= valid_in;
      end
      n_ff     <= n_in;
      x_ff     <= x_in;
      next_ff  <= next_in;
      steps_ff <= steps_in;
      root_ff  <= root_in;
      iter_ff  <= iter_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = valid_ff;
   assign rsp_root            = root_ff;
   assign rsp_iterations_used = iter_ff;

endmodule
`default_nettype wire

// ===== design/nisr_checker.sv =====
// Port-level assertions for the Newton integer square root core and their bind.
`default_nettype none
module nisr_checker
   import nisr_pkg::*;
(
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic signed [DATA_WIDTH-1:0] req_operand,
   input wire logic                         rsp_valid,
   input wire logic signed [DATA_WIDTH-1:0] rsp_root,
   input wire logic [LIMIT_WIDTH-1:0]       rsp_iterations_used,
   input wire logic                         csr_write_enable,
   input wire logic [LIMIT_WIDTH-1:0]       csr_write_data
);

   logic unused_csr;
   assign unused_csr = csr_write_enable ^ (^csr_write_data);

   negative_word_next_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operand[DATA_WIDTH-1]) |=>
         (rsp_valid && (rsp_root == '1) && (rsp_iterations_used == '0)))
      else $error("Negative operand did not return minus one in the next cycle.");

   positive_word_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_operand[DATA_WIDTH-1]) |=> (busy && !rsp_valid))
      else $error("Non-negative operand did not start an iteration sequence.");

   negative_root_has_no_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_root[DATA_WIDTH-1]) |-> (rsp_iterations_used == '0))
      else $error("A negative root was reported with Newton steps.");

   strobe_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result strobe while the core is still busy.");

endmodule

bind newton_integer_square_root_core nisr_checker u_nisr_checker (.*);
`default_nettype wire

// ===== tb/newton_integer_square_root_core_tb.sv =====
// Self-checking testbench for the Newton integer square root core.
`default_nettype none
module newton_integer_square_root_core_tb
   import nisr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] root;
      logic [LIMIT_WIDTH-1:0]       iterations_used;
   } root_word_type;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_MAX = '1;
   localparam int DRAIN_CYCLES = 4 * (DATA_WIDTH + 2);
   localparam int PHASE_COUNT = 11;
   localparam int PHASE_ITEMS = 48;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [DATA_WIDTH-1:0] req_operand;
   logic                         rsp_valid;
   logic signed [DATA_WIDTH-1:0] rsp_root;
   logic [LIMIT_WIDTH-1:0]       rsp_iterations_used;
   logic                         csr_write_enable;
   logic [LIMIT_WIDTH-1:0]       csr_write_data;

   root_word_type          expected_roots[$];
   logic [LIMIT_WIDTH-1:0] limit_copy;
   bit                     idling_on;
   int                     error_count;
   int                     operands_sent;
   int                     words_checked;
   int                     limit_writes;

   newton_integer_square_root_core uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operand         (req_operand),
      .rsp_valid           (rsp_valid),
      .rsp_root            (rsp_root),
      .rsp_iterations_used (rsp_iterations_used),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic root_word_type predict_root(logic signed [DATA_WIDTH-1:0] operand,
                                                  logic [LIMIT_WIDTH-1:0] limit);
      bit [DATA_WIDTH:0] n;
      bit [DATA_WIDTH:0] x;
      bit [DATA_WIDTH:0] next_x;
      int unsigned       steps;
      root_word_type     word;
      if (operand < 0) begin
         word.root = '1;
         word.iterations_used = '0;
         return word;
      end
      n = {1'b0, operand};
      x = n;
      next_x = (n + 1) >> 1;
      steps = 0;
      while (steps < limit && next_x < x) begin
         x = next_x;
         steps++;
         if (x == 0) begin
            break;
         end
         next_x = (x + n / x) >> 1;
      end
      word.root = x[DATA_WIDTH-1:0];
      word.iterations_used = steps[LIMIT_WIDTH-1:0];
      return word;
   endfunction

   task automatic report_error(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : check_words
      root_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_roots.size() == 0) begin
            report_error($sformatf("unexpected word root %0d iterations %0d",
                                   rsp_root, rsp_iterations_used));
         end else begin
            want = expected_roots.pop_front();
            if (rsp_root !== want.root) begin
               report_error($sformatf("word %0d root %0d, expected %0d",
                                      words_checked, rsp_root, want.root));
            end
            if (rsp_iterations_used !== want.iterations_used) begin
               report_error($sformatf("word %0d iterations_used %0d, expected %0d",
                                      words_checked, rsp_iterations_used,
                                      want.iterations_used));
            end
            words_checked++;
         end
      end
   end

   task automatic send_operand(logic signed [DATA_WIDTH-1:0] operand);
      @(negedge clock);
      start <= 1'b1;
      req_operand <= operand;
      do begin
         @(posedge clock);
      end while (busy);
      expected_roots.push_back(predict_root(operand, limit_copy));
      operands_sent++;
   endtask

   task automatic maybe_idle();
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         start <= 1'b0;
         req_operand <= $urandom;
         if ($urandom_range(0, 1) == 1) begin
            while (busy) begin
               @(negedge clock);
            end
         end
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_limit(logic [LIMIT_WIDTH-1:0] value);
      @(negedge clock);
      start <= 1'b0;
      wait (expected_roots.size() == 0);
      while (busy) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data <= LIMIT_WIDTH'($urandom);
      limit_copy = value;
      limit_writes++;
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
      logic [DATA_WIDTH-1:0] value;
      int unsigned           base;
      case ($urandom_range(0, 9))
         0, 1, 2: value = $urandom & 32'h7FFF_FFFF;
         3: value = $urandom;
         4, 5: value = $urandom_range(0, 1000);
         6: begin
            base = $urandom_range(0, 46340);
            value = base * base + $urandom_range(0, 2) - 1;
         end
         7: value = $urandom | 32'h8000_0000;
         8: value = ($urandom & 32'h7FFF_FFFF) >> $urandom_range(0, 31);
         default: value = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                               : $urandom_range(0, 3);
      endcase
      return value;
   endfunction

   task automatic test_boundary_operands();
      logic signed [DATA_WIDTH-1:0] operands[] = '{
         0, 1, 2, 3, 4, 8, 15, 16, 99, 100,
         32'h7FFF_FFFF, 32'h7FFF_FFFE, 2147395600, 2147395599,
         -1, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
      };
      foreach (operands[i]) begin
         send_operand(operands[i]);
      end
   endtask

   task automatic test_limit_extremes();
      write_limit('0);
      send_operand(32'h7FFF_FFFF);
      send_operand(5);
      write_limit(LIMIT_WIDTH'(1));
      send_operand(100);
      write_limit(LIMIT_MAX);
      send_operand(32'h7FFF_FFFF);
      send_operand(1000000);
      write_limit(LIMIT_WIDTH'(3));
      send_operand(65536);
   endtask

   task automatic test_random_operands();
      logic [LIMIT_WIDTH-1:0] limit;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: limit = LIMIT_MAX;
            1: limit = '0;
            2: limit = LIMIT_WIDTH'(1);
            PHASE_COUNT - 1: limit = LIMIT_RESET;
            default: limit = $urandom_range(0, 1) ? LIMIT_WIDTH'($urandom_range(2, 24))
                                                  : LIMIT_WIDTH'($urandom_range(0, 255));
         endcase
         idling_on = (phase < PHASE_COUNT - 2) && (phase % 3 != 2);
         write_limit(limit);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            maybe_idle();
            send_operand(pick_operand());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operand = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      limit_copy = LIMIT_RESET;
      idling_on = 1'b0;
      error_count = 0;
      operands_sent = 0;
      words_checked = 0;
      limit_writes = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_boundary_operands();
      test_limit_extremes();
      test_random_operands();

      @(negedge clock);
      start <= 1'b0;
      wait (expected_roots.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d operands under %0d iteration limit settings, extremes included.",
               operands_sent, limit_writes + 1);
      $display("Checked %0d result words against the predicted root and step count.",
               words_checked);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Run timed out with %0d result words still outstanding.",
               expected_roots.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire

// ===== newton_integer_square_root_core.f =====
design/nisr_pkg.sv
design/nisr_divider.sv
design/newton_integer_square_root_core.sv
design/nisr_checker.sv
tb/newton_integer_square_root_core_tb.sv
